// ----- sv/qse_pkg.sv -----
// package for the quicksort engine: widths, item types and the sequencer program
`timescale 1ns / 1ps

package qse_pkg;

   // store capacity and derived widths
   localparam int DEPTH       = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int STACK_W     = 2 * IDX_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [IDX_W:0]   wide_idx_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [SP_W-1:0]  sp_type;

   // input item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_item_type;

   // result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_set;
      logic                      overflow;
   } rsp_item_type;

   // one entry of the range stack
   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   // sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_PIVOT,
      ST_PIVOT_WAIT,
      ST_SCAN,
      ST_COMPARE,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_FINAL_A,
      ST_FINAL_B,
      ST_FINAL_C,
      ST_PUSH_SECOND,
      ST_EMIT_READ,
      ST_EMIT_SEND
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_NONE,
      COND_NO_LAST,
      COND_SMALL,
      COND_STACK_EMPTY,
      COND_EMPTY_RANGE,
      COND_SCAN_DONE,
      COND_NOT_LE,
      COND_MORE_OUT
   } cond_type;

   // element store read address source
   typedef enum logic [1:0] {
      RD_HI,
      RD_K,
      RD_PLACE,
      RD_OUT
   } raddr_type;

   // element store write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_LOAD,
      WR_K_FROM_READ,
      WR_PLACE_FROM_TMP,
      WR_HI_FROM_READ,
      WR_PLACE_FROM_PIVOT
   } wsel_type;

   // range stack push source
   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_ROOT,
      PUSH_FIRST,
      PUSH_SECOND
   } push_type;

   // scan index update
   typedef enum logic [1:0] {
      K_HOLD,
      K_INC,
      K_INC_ON_JUMP
   } kstep_type;

   // one control word
   typedef struct packed {
      cond_type  cond;
      step_type  jump_to;
      step_type  follow;
      raddr_type raddr;
      wsel_type  wsel;
      push_type  push;
      logic      pop;
      logic      load_range;
      logic      load_pivot;
      logic      load_tmp;
      logic      inc_place;
      kstep_type kstep;
      logic      emit;
      logic      clear_out;
   } ctrl_word_type;

   // control store: cond, jump, follow, raddr, wsel, push,
   // pop, load_range, load_pivot, load_tmp, inc_place, kstep, emit, clear_out
   function automatic ctrl_word_type program_word(step_type step);
      ctrl_word_type w;
      unique case (step)
         ST_IDLE:        w = '{COND_NO_LAST, ST_IDLE, ST_INIT, RD_OUT, WR_LOAD, PUSH_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_INIT:        w = '{COND_SMALL, ST_EMIT_READ, ST_POP, RD_OUT, WR_NONE, PUSH_ROOT,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b1};
         ST_POP:         w = '{COND_STACK_EMPTY, ST_EMIT_READ, ST_POP_WAIT, RD_OUT, WR_NONE,
                               PUSH_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_POP_WAIT:    w = '{COND_EMPTY_RANGE, ST_POP, ST_PIVOT, RD_OUT, WR_NONE, PUSH_NONE,
                               1'b0, 1'b1, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_PIVOT:       w = '{COND_NONE, ST_PIVOT_WAIT, ST_PIVOT_WAIT, RD_HI, WR_NONE,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_PIVOT_WAIT:  w = '{COND_NONE, ST_SCAN, ST_SCAN, RD_OUT, WR_NONE, PUSH_NONE,
                               1'b0, 1'b0, 1'b1, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_SCAN:        w = '{COND_SCAN_DONE, ST_FINAL_A, ST_COMPARE, RD_K, WR_NONE,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_COMPARE:     w = '{COND_NOT_LE, ST_SCAN, ST_SWAP_A, RD_PLACE, WR_NONE, PUSH_NONE,
                               1'b0, 1'b0, 1'b0, 1'b1, 1'b0, K_INC_ON_JUMP, 1'b0, 1'b0};
         ST_SWAP_A:      w = '{COND_NONE, ST_SWAP_B, ST_SWAP_B, RD_OUT, WR_K_FROM_READ,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_SWAP_B:      w = '{COND_NONE, ST_SCAN, ST_SCAN, RD_OUT, WR_PLACE_FROM_TMP,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, K_INC, 1'b0, 1'b0};
         ST_FINAL_A:     w = '{COND_NONE, ST_FINAL_B, ST_FINAL_B, RD_PLACE, WR_NONE,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_FINAL_B:     w = '{COND_NONE, ST_FINAL_C, ST_FINAL_C, RD_OUT, WR_HI_FROM_READ,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_FINAL_C:     w = '{COND_NONE, ST_PUSH_SECOND, ST_PUSH_SECOND, RD_OUT,
                               WR_PLACE_FROM_PIVOT, PUSH_FIRST,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_PUSH_SECOND: w = '{COND_NONE, ST_POP, ST_POP, RD_OUT, WR_NONE, PUSH_SECOND,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_EMIT_READ:   w = '{COND_NONE, ST_EMIT_SEND, ST_EMIT_SEND, RD_OUT, WR_NONE,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b0, 1'b0};
         ST_EMIT_SEND:   w = '{COND_MORE_OUT, ST_EMIT_READ, ST_IDLE, RD_OUT, WR_NONE,
                               PUSH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_HOLD, 1'b1, 1'b0};
      endcase
      return w;
   endfunction

endpackage

// ----- sv/qse_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/quicksort_engine_core.sv -----
// quicksort engine top level: microcoded sequencer over an element store and a range stack
// loading: one item per cycle while busy is low; the last item starts the sort
// sorting: each partition loads the pivot from the top of its range and then scans the range;
//    each element that goes left of the pivot takes an extra swap (one store port)
// emission: each result is strobed for one cycle; the receiver cannot stall
// reset: synchronous, clears sequencer, count, drop flag and stack pointer; no clearing pass
`timescale 1ns / 1ps

module quicksort_engine_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  qse_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output qse_pkg::rsp_item_type rsp_item
);

   // sequencer
   qse_pkg::step_type      pc_ff, pc_in;
   qse_pkg::ctrl_word_type cw;
   logic                   cond_true;

   // control state
   qse_pkg::count_type count_ff, count_in;
   logic               dropped_ff, dropped_in;
   qse_pkg::sp_type    sp_ff, sp_in;

   // datapath registers
   qse_pkg::idx_type           lo_ff, lo_in;
   qse_pkg::idx_type           hi_ff, hi_in;
   qse_pkg::idx_type           place_ff, place_in;
   qse_pkg::idx_type           k_ff, k_in;
   qse_pkg::idx_type           out_ff, out_in;
   logic signed [qse_pkg::VALUE_W-1:0] pivot_ff, pivot_in;
   logic signed [qse_pkg::VALUE_W-1:0] tmp_ff, tmp_in;
   qse_pkg::range_type         second_ff, second_in;
   logic                       second_ok_ff, second_ok_in;

   // ram ports
   logic                          st_wr_en;
   qse_pkg::idx_type              st_wr_addr, st_rd_addr;
   logic [qse_pkg::VALUE_W-1:0]   st_wr_data, st_rd;
   logic                          sk_wr_en;
   qse_pkg::idx_type              sk_wr_addr, sk_rd_addr;
   logic [qse_pkg::STACK_W-1:0]   sk_rd_raw;
   qse_pkg::range_type            sk_rd, push_entry;
   logic                          push_ok;

   // status
   logic                 accept;
   logic                 store_full;
   logic                 last_out;
   qse_pkg::wide_idx_type q_w, lo_w, hi_w;
   logic                 left_ok, right_ok, left_big;
   qse_pkg::range_type   left_range, right_range, first_range;

   assign busy     = (pc_ff != qse_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign store_full = (count_ff >= qse_pkg::CNT_W'(qse_pkg::DEPTH));
   assign last_out = ({1'b0, out_ff} == (count_ff - qse_pkg::CNT_W'(1)));
   assign sk_rd    = sk_rd_raw;

   // partition outcome and sub-ranges
   assign q_w  = {1'b0, place_ff};
   assign lo_w = {1'b0, lo_ff};
   assign hi_w = {1'b0, hi_ff};
   assign left_ok  = (q_w >= lo_w + qse_pkg::wide_idx_type'(2));
   assign right_ok = (q_w + qse_pkg::wide_idx_type'(1) < hi_w);
   assign left_big = ((place_ff - lo_ff) > (hi_ff - place_ff));
   assign left_range  = '{lo: lo_ff, hi: place_ff - qse_pkg::idx_type'(1)};
   assign right_range = '{lo: place_ff + qse_pkg::idx_type'(1), hi: hi_ff};
   assign first_range = (left_ok && right_ok) ? (left_big ? left_range : right_range)
                      : (left_ok ? left_range : right_range);

   // jump condition
   always_comb begin
      unique case (cw.cond)
         qse_pkg::COND_NONE:        cond_true = 1'b0;
         qse_pkg::COND_NO_LAST:     cond_true = !(start && req_item.last);
         qse_pkg::COND_SMALL:       cond_true = (count_ff < qse_pkg::CNT_W'(2));
         qse_pkg::COND_STACK_EMPTY: cond_true = (sp_ff == '0);
         qse_pkg::COND_EMPTY_RANGE: cond_true = (sk_rd.lo >= sk_rd.hi);
         qse_pkg::COND_SCAN_DONE:   cond_true = (k_ff == hi_ff);
         qse_pkg::COND_NOT_LE:      cond_true = ($signed(st_rd) > pivot_ff);
         qse_pkg::COND_MORE_OUT:    cond_true = !last_out;
         default:                   cond_true = 1'b0;
      endcase
   end

   // step register
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= qse_pkg::ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // next step from the control store
   always_comb begin
      cw    = qse_pkg::program_word(pc_ff);
      pc_in = cond_true ? cw.jump_to : cw.follow;
   end

   // element store write select
   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = k_ff;
      st_wr_data = st_rd;
      unique case (cw.wsel)
         qse_pkg::WR_NONE: begin
            st_wr_en = 1'b0;
         end
         qse_pkg::WR_LOAD: begin
            st_wr_en   = accept && !store_full;
            st_wr_addr = count_ff[qse_pkg::IDX_W-1:0];
            st_wr_data = req_item.value;
         end
         qse_pkg::WR_K_FROM_READ: begin
            st_wr_en   = 1'b1;
            st_wr_addr = k_ff;
            st_wr_data = st_rd;
         end
         qse_pkg::WR_PLACE_FROM_TMP: begin
            st_wr_en   = 1'b1;
            st_wr_addr = place_ff;
            st_wr_data = tmp_ff;
         end
         qse_pkg::WR_HI_FROM_READ: begin
            st_wr_en   = 1'b1;
            st_wr_addr = hi_ff;
            st_wr_data = st_rd;
         end
         qse_pkg::WR_PLACE_FROM_PIVOT: begin
            st_wr_en   = 1'b1;
            st_wr_addr = place_ff;
            st_wr_data = pivot_ff;
         end
         default: begin
            st_wr_en = 1'b0;
         end
      endcase
   end

   // element store read select
   always_comb begin
      unique case (cw.raddr)
         qse_pkg::RD_HI:    st_rd_addr = hi_ff;
         qse_pkg::RD_K:     st_rd_addr = k_ff;
         qse_pkg::RD_PLACE: st_rd_addr = place_ff;
         qse_pkg::RD_OUT:   st_rd_addr = out_ff;
      endcase
   end

   // range stack push select
   always_comb begin
      unique case (cw.push)
         qse_pkg::PUSH_NONE: begin
            push_ok    = 1'b0;
            push_entry = first_range;
         end
         qse_pkg::PUSH_ROOT: begin
            push_ok    = (count_ff >= qse_pkg::CNT_W'(2));
            push_entry = '{lo: '0,
                           hi: qse_pkg::IDX_W'(count_ff - qse_pkg::CNT_W'(1))};
         end
         qse_pkg::PUSH_FIRST: begin
            push_ok    = left_ok || right_ok;
            push_entry = first_range;
         end
         qse_pkg::PUSH_SECOND: begin
            push_ok    = second_ok_ff;
            push_entry = second_ff;
         end
      endcase
   end

   assign sk_wr_en   = push_ok && (sp_ff < qse_pkg::SP_W'(qse_pkg::STACK_DEPTH));
   assign sk_wr_addr = sp_ff[qse_pkg::IDX_W-1:0];
   assign sk_rd_addr = qse_pkg::IDX_W'(sp_ff - qse_pkg::SP_W'(1));

   // control state update
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      sp_in      = sp_ff;
      if (cw.wsel == qse_pkg::WR_LOAD && accept) begin
         if (store_full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + qse_pkg::CNT_W'(1);
         end
      end
      if (sk_wr_en) begin
         sp_in = sp_ff + qse_pkg::SP_W'(1);
      end else if (cw.pop && sp_ff != '0) begin
         sp_in = sp_ff - qse_pkg::SP_W'(1);
      end
      if (cw.emit && last_out) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   // datapath update
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      place_in     = place_ff;
      k_in         = k_ff;
      out_in       = out_ff;
      pivot_in     = pivot_ff;
      tmp_in       = tmp_ff;
      second_in    = second_ff;
      second_ok_in = second_ok_ff;
      if (cw.load_range) begin
         lo_in    = sk_rd.lo;
         hi_in    = sk_rd.hi;
         place_in = sk_rd.lo;
         k_in     = sk_rd.lo;
      end
      if (cw.load_pivot) begin
         pivot_in = st_rd;
      end
      if (cw.load_tmp) begin
         tmp_in = st_rd;
      end
      if (cw.inc_place) begin
         place_in = place_ff + qse_pkg::idx_type'(1);
      end
      unique case (cw.kstep)
         qse_pkg::K_HOLD:        k_in = cw.load_range ? sk_rd.lo : k_ff;
         qse_pkg::K_INC:         k_in = k_ff + qse_pkg::idx_type'(1);
         qse_pkg::K_INC_ON_JUMP: k_in = cond_true ? k_ff + qse_pkg::idx_type'(1) : k_ff;
         default:                k_in = k_ff;
      endcase
      if (cw.push == qse_pkg::PUSH_FIRST) begin
         second_ok_in = left_ok && right_ok;
         second_in    = left_big ? right_range : left_range;
      end
      if (cw.clear_out) begin
         out_in = '0;
      end else if (cw.emit && !last_out) begin
         out_in = out_ff + qse_pkg::idx_type'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sp_ff      <= '0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         sp_ff      <= sp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      place_ff     <= place_in;
      k_ff         <= k_in;
      out_ff       <= out_in;
      pivot_ff     <= pivot_in;
      tmp_ff       <= tmp_in;
      second_ff    <= second_in;
      second_ok_ff <= second_ok_in;
   end

   // element store
   qse_ram #(
      .WIDTH(qse_pkg::VALUE_W),
      .DEPTH(qse_pkg::DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd)
   );

   // range stack
   qse_ram #(
      .WIDTH(qse_pkg::STACK_W),
      .DEPTH(qse_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (sk_wr_en),
      .wr_addr(sk_wr_addr),
      .wr_data(push_entry),
      .rd_addr(sk_rd_addr),
      .rd_data(sk_rd_raw)
   );

   // result item
   assign rsp_strobe            = cw.emit;
   assign rsp_item.sorted_value = st_rd;
   assign rsp_item.end_of_set   = last_out;
   assign rsp_item.overflow     = dropped_ff;

   // scan indices stay ordered inside the range
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == qse_pkg::ST_SCAN) |-> (place_ff <= k_ff && k_ff <= hi_ff))
      else $error("scan indices out of order");

   // stack pointer never passes capacity
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= qse_pkg::SP_W'(qse_pkg::STACK_DEPTH))
      else $error("range stack pointer out of bounds");

   // final result returns the block to idle with an empty set
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.end_of_set) |=> (!busy && count_ff == '0 && !dropped_ff))
      else $error("block not idle after final result");

   // a last item starts the sort
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.last) |=> busy)
      else $error("last item did not start the sort");

   // results only come from stored elements
   a_emit_in_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff != '0 && {1'b0, out_ff} < count_ff))
      else $error("result index beyond stored set");

endmodule

// ----- dv/quicksort_engine_core_test.sv -----
// self-checking testbench for the quicksort engine: sends sets, predicts sorted results, checks each
`timescale 1ns / 1ps

module quicksort_engine_core_test;

   localparam int RANDOM_ITEMS = 90;
   localparam int QUIET_ITEMS  = 20;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_REPORTS  = 10;

   typedef logic signed [qse_pkg::VALUE_W-1:0] value_type;

   // shapes of the random sets
   typedef enum int {
      SET_WIDE,
      SET_NARROW,
      SET_ASCENDING,
      SET_DESCENDING,
      SET_CONSTANT,
      SET_OVERSIZE
   } set_shape_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   qse_pkg::req_item_type req_item;
   logic                  rsp_strobe;
   qse_pkg::rsp_item_type rsp_item;

   // predictor state: the set collected so far
   value_type    held_values[qse_pkg::DEPTH];
   int           held_count;
   logic         held_dropped;

   qse_pkg::rsp_item_type sorted_pending[$];
   int           failures;
   int           cycle_count;
   bit           idle_bursts;

   quicksort_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // result checker: every strobed item against the oldest expectation
   always @(posedge clock) begin
      qse_pkg::rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (sorted_pending.size() == 0) begin
            note_failure($sformatf("unexpected item value %0d end %b ovf %b",
                                   rsp_item.sorted_value, rsp_item.end_of_set,
                                   rsp_item.overflow));
         end else begin
            want = sorted_pending.pop_front();
            if (rsp_item.sorted_value !== want.sorted_value ||
                rsp_item.end_of_set !== want.end_of_set ||
                rsp_item.overflow !== want.overflow)
               note_failure($sformatf("expected value %0d end %b ovf %b, got %0d end %b ovf %b",
                                      want.sorted_value, want.end_of_set, want.overflow,
                                      rsp_item.sorted_value, rsp_item.end_of_set,
                                      rsp_item.overflow));
         end
      end
   end

   // send one item, entered at a falling edge; updates the predicted results on acceptance
   task automatic send_value(input value_type v, input logic is_last);
      value_type key;
      int        j;
      int        gap;
      start    <= 1'b1;
      req_item <= '{value: v, last: is_last};
      do @(posedge clock); while (busy);
      if (held_count < qse_pkg::DEPTH) begin
         held_values[held_count] = v;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (is_last) begin
         // ascending order of the held set
         for (int i = 1; i < held_count; i++) begin
            key = held_values[i];
            j   = i - 1;
            while (j >= 0 && held_values[j] > key) begin
               held_values[j + 1] = held_values[j];
               j--;
            end
            held_values[j + 1] = key;
         end
         for (int i = 0; i < held_count; i++)
            sorted_pending.push_back('{sorted_value: held_values[i],
                                       end_of_set:   (i == held_count - 1),
                                       overflow:     held_dropped});
         held_count   = 0;
         held_dropped = 1'b0;
      end
      @(negedge clock);
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
   endtask

   // send a whole set, the final item flagged last
   task automatic send_set(input value_type vals[$]);
      foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
   endtask

   task automatic test_single_item();
      send_set('{32'sh8000_0000});
      send_set('{32'sh7fff_ffff});
   endtask

   task automatic test_extremes();
      send_set('{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0000, 32'sh7fff_ffff});
   endtask

   task automatic test_duplicates();
      send_set('{5, 5, 5, 5});
      send_set('{-3, 7, -3, 7, 0});
   endtask

   task automatic test_presorted();
      send_set('{-20, -1, 4, 9});
      send_set('{9, 4, -1, -20});
   endtask

   // full store with one surplus item, the last flag on the dropped item
   task automatic test_capacity();
      value_type vals[$];
      for (int i = 0; i < qse_pkg::DEPTH + 1; i++) vals.push_back(value_type'($urandom()));
      send_set(vals);
      // overflow must not carry into the next set
      send_set('{3, 1, 2});
   endtask

   task automatic test_random_sets();
      value_type     vals[$];
      set_shape_type shape;
      int            size;
      int            sent;
      value_type     base;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_bursts = (sent < RANDOM_ITEMS - QUIET_ITEMS);
         shape = set_shape_type'($urandom_range(0, 5));
         if (shape == SET_OVERSIZE && $urandom_range(0, 3) != 0) shape = SET_WIDE;
         size = (shape == SET_OVERSIZE)
              ? $urandom_range(qse_pkg::DEPTH - 2, qse_pkg::DEPTH + 3)
              : ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         base = value_type'($urandom());
         vals.delete();
         for (int i = 0; i < size; i++) begin
            case (shape)
               SET_NARROW:     vals.push_back($urandom_range(0, 6) - 3);
               SET_ASCENDING:  vals.push_back(base + i);
               SET_DESCENDING: vals.push_back(base - i);
               SET_CONSTANT:   vals.push_back(base);
               default:        vals.push_back(value_type'($urandom()));
            endcase
         end
         send_set(vals);
         sent += size;
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      held_count   = 0;
      held_dropped = 1'b0;
      failures     = 0;
      cycle_count  = 0;
      idle_bursts  = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_item();
      test_extremes();
      test_duplicates();
      test_presorted();
      test_capacity();
      test_random_sets();
      start <= 1'b0;

      // drain outstanding results, then keep watching for stray strobes
      while (sorted_pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/qse_pkg.sv
sv/qse_ram.sv
sv/quicksort_engine_core.sv
dv/quicksort_engine_core_test.sv
